// ----- rtl/tlbpt_pkg.sv -----
// shared constants and types for the page translator
`default_nettype none

package tlbpt_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int IDX_W       = $clog2(TLB_ENTRIES);
    localparam int PAGE_W      = 8;
    localparam int OFFSET_W    = 8;
    localparam int ADDR_W      = PAGE_W + OFFSET_W;
    localparam int PAGE_COUNT  = 1 << PAGE_W;
    localparam int CNT_W       = 32;

    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

endpackage

`default_nettype wire

// ----- rtl/tlbpt_cam.sv -----
// tlb tag store with parallel compare and true lru recency ages
`default_nettype none

module tlbpt_cam
    import tlbpt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  lookup_en,
    input  wire page_t page,
    output logic       hit
);

    page_t                  tag_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] valid_reg;
    idx_t                   age_reg [TLB_ENTRIES];

    logic [TLB_ENTRIES-1:0] match_vec;
    idx_t                   match_idx;
    idx_t                   free_idx;
    idx_t                   lru_idx;
    idx_t                   touch_idx;
    idx_t                   old_age;
    logic                   any_free;

    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        lru_idx   = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            match_vec[i] = valid_reg[i] && (tag_reg[i] == page);
            if (match_vec[i])
            begin
                match_idx = idx_t'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = idx_t'(i);
            end
            if (age_reg[i] == idx_t'(TLB_ENTRIES - 1))
            begin
                lru_idx = idx_t'(i);
            end
        end
        hit       = |match_vec;
        any_free  = ~&valid_reg;
        touch_idx = hit ? match_idx : (any_free ? free_idx : lru_idx);
        old_age   = age_reg[touch_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                age_reg[i] <= idx_t'(i);
            end
        end
        else if (lookup_en)
        begin
            if (!hit)
            begin
                valid_reg[touch_idx] <= 1'b1;
            end
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                if (idx_t'(i) == touch_idx)
                begin
                    age_reg[i] <= '0;
                end
                else if (age_reg[i] < old_age)
                begin
                    age_reg[i] <= age_reg[i] + idx_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup_en && !hit)
        begin
            tag_reg[touch_idx] <= page;
        end
    end

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("page matched more than one tlb entry");

    a_touched_valid: assert property (@(posedge clk) disable iff (!rst_n)
        lookup_en |=> valid_reg[$past(touch_idx)])
        else $error("touched entry not valid after lookup");

    a_touched_youngest: assert property (@(posedge clk) disable iff (!rst_n)
        lookup_en |=> age_reg[$past(touch_idx)] == '0)
        else $error("touched entry not most recent");

endmodule

`default_nettype wire

// ----- rtl/tlbpt_page_map.sv -----
// per-page loaded bitmap and fault detection
`default_nettype none

module tlbpt_page_map
    import tlbpt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  miss_en,
    input  wire page_t page,
    output logic       fault
);

    logic [PAGE_COUNT-1:0] loaded_reg;

    assign fault = miss_en && !loaded_reg[page];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
        end
        else if (miss_en)
        begin
            loaded_reg[page] <= 1'b1;
        end
    end

    a_marked_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        miss_en |=> loaded_reg[$past(page)])
        else $error("missed page not marked loaded");

endmodule

`default_nettype wire

// ----- rtl/tlb_page_translator_lru.sv -----
// top level of the fully associative tlb with lru replacement
//
// input channel: in_valid / in_stall carry one logical address word; the
// word is taken at a rising edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall carry one result word per input:
// physical address, page number, hit and fault flags and the running
// hit and fault totals (32 bits, wrapping).
// path: the input word is held in the input register, then tag compare,
// bitmap check and lru update feed the result register, which raises out_valid.
// throughput: one word per cycle while out_stall does not hold a pending
// result, set by the parallel tag compare and age update over all tlb entries.
// reset: all tlb entries invalid, ages ordered by entry index, the loaded
// bitmap and both totals cleared; no sweep, the block takes words at once.
// stall: while out_stall holds a pending result, the result register and
// input register hold, and in_stall rises once the input register is full;
// no word is dropped or repeated.
`default_nettype none

module tlb_page_translator_lru
    import tlbpt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire addr_t vaddr,
    output logic       out_valid,
    input  wire logic  out_stall,
    output addr_t      paddr,
    output page_t      vpage,
    output logic       tlb_hit,
    output logic       page_fault,
    output cnt_t       hit_total,
    output cnt_t       fault_total
);

    logic  s1_valid_reg;
    addr_t s1_addr_reg;

    logic  out_valid_reg;
    addr_t phys_reg;
    page_t page_reg;
    logic  hit_reg;
    logic  fault_reg;
    cnt_t  hit_cnt_reg;
    cnt_t  fault_cnt_reg;
    cnt_t  hit_cnt_next;
    cnt_t  fault_cnt_next;

    logic  out_take;
    logic  s1_adv;
    page_t s1_page;
    logic  lookup_hit;
    logic  miss_fault;

    assign out_take = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_take;
    assign in_stall = s1_valid_reg && !out_take;
    assign s1_page  = s1_addr_reg[ADDR_W-1:OFFSET_W];

    tlbpt_cam u_cam (
        .clk       (clk),
        .rst_n     (rst_n),
        .lookup_en (s1_adv),
        .page      (s1_page),
        .hit       (lookup_hit)
    );

    tlbpt_page_map u_page_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .miss_en (s1_adv && !lookup_hit),
        .page    (s1_page),
        .fault   (miss_fault)
    );

    assign hit_cnt_next   = hit_cnt_reg + cnt_t'(lookup_hit);
    assign fault_cnt_next = fault_cnt_reg + cnt_t'(miss_fault);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_take)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_adv)
            begin
                hit_cnt_reg   <= hit_cnt_next;
                fault_cnt_reg <= fault_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_addr_reg <= vaddr;
        end
        if (s1_adv)
        begin
            phys_reg  <= {s1_page, s1_addr_reg[OFFSET_W-1:0]};
            page_reg  <= s1_page;
            hit_reg   <= lookup_hit;
            fault_reg <= miss_fault;
        end
    end

    assign out_valid   = out_valid_reg;
    assign paddr       = phys_reg;
    assign vpage       = page_reg;
    assign tlb_hit     = hit_reg;
    assign page_fault  = fault_reg;
    assign hit_total   = hit_cnt_reg;
    assign fault_total = fault_cnt_reg;

    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && fault_reg))
        else $error("hit and fault flagged together");

    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && miss_fault |=> fault_cnt_reg == $past(fault_cnt_reg) + cnt_t'(1))
        else $error("fault not counted");

endmodule

`default_nettype wire

// ----- sim/tlb_page_translator_lru_checker.sv -----
// checker for the page translator: predicts each translation and compares results
module tlb_page_translator_lru_checker
    import tlbpt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  in_stall,
    input  wire addr_t vaddr,
    input  wire logic  out_valid,
    input  wire logic  out_stall,
    input  wire addr_t paddr,
    input  wire page_t vpage,
    input  wire logic  tlb_hit,
    input  wire logic  page_fault,
    input  wire cnt_t  hit_total,
    input  wire cnt_t  fault_total,
    output int         mismatch_count,
    output int         pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        addr_t phys;
        page_t page;
        logic  hit;
        logic  fault;
        cnt_t  hits;
        cnt_t  faults;
    } xlate_t;

    xlate_t xlate_queue[$];

    page_t tag_of[TLB_ENTRIES];
    logic  entry_ok[TLB_ENTRIES];
    idx_t  age_of[TLB_ENTRIES];
    logic  page_present[PAGE_COUNT];
    cnt_t  hit_tally;
    cnt_t  fault_tally;

    assign pending_words = xlate_queue.size();

    task automatic clear_translator();
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            tag_of[i]   = '0;
            entry_ok[i] = 1'b0;
            age_of[i]   = idx_t'(i);
        end
        for (int p = 0; p < PAGE_COUNT; p++)
            page_present[p] = 1'b0;
        hit_tally   = '0;
        fault_tally = '0;
    endtask

    task automatic predict_translation(input addr_t la);
        page_t  pg;
        logic   found;
        logic   free_found;
        int     slot;
        idx_t   old_age;
        xlate_t x;
        pg         = la[ADDR_W-1:OFFSET_W];
        found      = 1'b0;
        free_found = 1'b0;
        slot       = 0;
        x          = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
            if (!found && entry_ok[i] && tag_of[i] == pg)
            begin
                found = 1'b1;
                slot  = i;
            end
        if (found)
            hit_tally = hit_tally + 1;
        else
        begin
            if (!page_present[pg])
            begin
                x.fault          = 1'b1;
                page_present[pg] = 1'b1;
                fault_tally      = fault_tally + 1;
            end
            for (int i = 0; i < TLB_ENTRIES; i++)
                if (!free_found && !entry_ok[i])
                begin
                    free_found = 1'b1;
                    slot       = i;
                end
            if (!free_found)
                for (int i = 0; i < TLB_ENTRIES; i++)
                    if (age_of[i] == idx_t'(TLB_ENTRIES - 1))
                        slot = i;
            tag_of[slot]   = pg;
            entry_ok[slot] = 1'b1;
        end
        // touched entry becomes youngest, younger ones age by one
        old_age = age_of[slot];
        for (int i = 0; i < TLB_ENTRIES; i++)
            if (age_of[i] < old_age)
                age_of[i] = age_of[i] + 1'b1;
        age_of[slot] = '0;
        x.phys   = {pg, la[OFFSET_W-1:0]};
        x.page   = pg;
        x.hit    = found;
        x.hits   = hit_tally;
        x.faults = fault_tally;
        xlate_queue.push_back(x);
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            $error("%s expected %0h actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        xlate_t x;
        if (!rst_n)
        begin
            clear_translator();
            xlate_queue.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_translation(vaddr);
            if (out_valid && !out_stall)
            begin
                if (xlate_queue.size() == 0)
                begin
                    $error("result word with no translation pending");
                    mismatch_count++;
                end
                else
                begin
                    x = xlate_queue.pop_front();
                    check_field("paddr", x.phys, paddr);
                    check_field("vpage", x.page, vpage);
                    check_field("tlb_hit", x.hit, tlb_hit);
                    check_field("page_fault", x.fault, page_fault);
                    check_field("hit_total", x.hits, hit_total);
                    check_field("fault_total", x.faults, fault_total);
                end
            end
        end
    end

    initial mismatch_count = 0;

endmodule

// ----- sim/tlb_page_translator_lru_tb.sv -----
// testbench top: drives address words, idles both sides and reports the verdict
module tlb_page_translator_lru_tb;
    import tlbpt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 48;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    addr_t vaddr = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    addr_t paddr;
    page_t vpage;
    logic  tlb_hit;
    logic  page_fault;
    cnt_t  hit_total;
    cnt_t  fault_total;

    int    mismatch_count;
    int    pending_words;
    int    idle_pct = 0;
    int    stall_pct = 0;
    bit    hold_request = 1'b0;
    int    cycle_count = 0;
    page_t hot_pages[24];
    int    hot_size;

    tlb_page_translator_lru dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .vaddr       (vaddr),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .paddr       (paddr),
        .vpage       (vpage),
        .tlb_hit     (tlb_hit),
        .page_fault  (page_fault),
        .hit_total   (hit_total),
        .fault_total (fault_total)
    );

    tlb_page_translator_lru_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .vaddr          (vaddr),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .paddr          (paddr),
        .vpage          (vpage),
        .tlb_hit        (tlb_hit),
        .page_fault     (page_fault),
        .hit_total      (hit_total),
        .fault_total    (fault_total),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver side, long hold-off counted here
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_word(input addr_t la);
        in_valid <= 1'b1;
        vaddr    <= la;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    initial
    begin
        addr_t la;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, hits, fills up to a full tlb, lru eviction, miss on a loaded page
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h00FF);
        send_word(16'hFF00);
        for (int p = 1; p <= 14; p++)
            send_word({page_t'(p), 8'(p * 17)});
        send_word(16'h5AA5);
        send_word(16'hFF5A);
        send_word(16'h00A5);
        send_word(16'hA55A);
        send_word(16'h0E3C);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            hot_size = $urandom_range(8, 24);
            foreach (hot_pages[i])
                hot_pages[i] = page_t'($urandom_range(0, 255));
            for (int n = 0; n < 95; n++)
            begin
                if (phase == 0 && n == 30)
                    hold_request = 1'b1;
                la[OFFSET_W-1:0] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < 75)
                    la[ADDR_W-1:OFFSET_W] = hot_pages[$urandom_range(0, hot_size - 1)];
                else
                    la[ADDR_W-1:OFFSET_W] = page_t'($urandom_range(0, 255));
                send_word(la);
            end
        end

        in_valid  <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
